/* rtl/bebm_pkg.sv */
`timescale 1ns / 1ps

package bebm_pkg;

   localparam int LANES = 8;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      SIZE_BYTE  = 3'd0,
      SIZE_HALF  = 3'd1,
      SIZE_WORD  = 3'd2,
      SIZE_DWORD = 3'd3
   } size_type;

   typedef enum logic [1:0] {
      TRAP_NONE  = 2'd0,
      TRAP_RANGE = 2'd1,
      TRAP_ALIGN = 2'd2
   } trap_type;

   // What the decoder hands to the memory and to the read pipeline.
   typedef struct packed {
      logic        write_en;
      logic        read_ok;
      trap_type    trap;
      logic [2:0]  offset;
      logic [1:0]  size;
      logic        sext;
      logic [7:0]  byte_en;
      logic [63:0] lane_data;
   } access_type;

   // Side data that travels with each accepted beat while the memory is read.
   typedef struct packed {
      logic       read_ok;
      trap_type   trap;
      logic [2:0] offset;
      logic [1:0] size;
      logic       sext;
   } meta_type;

endpackage

/* rtl/bebm_if.sv */
`timescale 1ns / 1ps

interface bebm_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] address;
   logic [2:0]  access_size;
   logic        sign_extend;
   logic [63:0] write_data;

   modport source (output valid, operation, address, access_size, sign_extend, write_data,
                   input ready);
   modport sink (input valid, operation, address, access_size, sign_extend, write_data,
                 output ready);
endinterface

interface bebm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] read_data;
   logic [1:0]  trap_code;

   modport source (output valid, read_data, trap_code, input ready);
   modport sink (input valid, read_data, trap_code, output ready);
endinterface

/* rtl/bebm_ram.sv */
`timescale 1ns / 1ps

module bebm_ram #(
   parameter int DEPTH = 8192,
   parameter int ROW_W = 13
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ROW_W-1:0]   wr_row,
   input  logic [7:0]         wr_be,
   input  logic [63:0]        wr_data,
   input  logic               rd_en,
   input  logic [ROW_W-1:0]   rd_row,
   output logic [63:0]        rd_data
);
   import bebm_pkg::*;

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < LANES; k++) begin
            if (wr_be[k]) begin
               mem[wr_row][8*k +: 8] <= wr_data[8*k +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bebm_decode.sv */
`timescale 1ns / 1ps

module bebm_decode #(
   parameter int MEM_BYTES = 65536,
   parameter int ROW_W     = 13
) (
   input  logic                  operation,
   input  logic [31:0]           address,
   input  logic [2:0]            access_size,
   input  logic                  sign_extend,
   input  logic [63:0]           write_data,
   output logic [ROW_W-1:0]      row,
   output bebm_pkg::access_type  acc
);
   import bebm_pkg::*;

   logic [3:0]  nbytes;
   logic [32:0] addr_ext;
   logic [32:0] addr_end;
   logic        size_ok;
   trap_type    trap;
   logic        lane_hit [LANES];
   logic [3:0]  lane_rel [LANES];
   logic [2:0]  lane_src [LANES];

   assign size_ok  = (access_size <= SIZE_DWORD);
   assign nbytes   = 4'd1 << access_size[1:0];
   assign addr_ext = {1'b0, address};
   assign addr_end = addr_ext + 33'(nbytes);
   assign row      = address[ROW_W+2:3];

   // The range check runs ahead of the alignment check.
   always_comb begin
      priority if (!size_ok) begin
         trap = (addr_ext >= 33'(MEM_BYTES)) ? TRAP_RANGE : TRAP_ALIGN;
      end else if (addr_end > 33'(MEM_BYTES)) begin
         trap = TRAP_RANGE;
      end else if ((address[2:0] & 3'(nbytes - 4'd1)) != 3'd0) begin
         trap = TRAP_ALIGN;
      end else begin
         trap = TRAP_NONE;
      end
   end

   // The lowest address holds the most significant byte of the value.
   always_comb begin
      acc.write_en  = (trap == TRAP_NONE) && (operation == OP_WRITE);
      acc.read_ok   = (trap == TRAP_NONE) && (operation == OP_READ);
      acc.trap      = trap;
      acc.offset    = address[2:0];
      acc.size      = access_size[1:0];
      acc.sext      = sign_extend;
      for (int k = 0; k < LANES; k++) begin
         lane_rel[k] = 4'(k) - {1'b0, address[2:0]};
         lane_hit[k] = (4'(k) >= {1'b0, address[2:0]}) && (lane_rel[k] < nbytes);
         lane_src[k] = 3'(nbytes - 4'd1 - lane_rel[k]);
         acc.byte_en[k]          = acc.write_en && lane_hit[k];
         acc.lane_data[8*k +: 8] = write_data[{lane_src[k], 3'b000} +: 8];
      end
   end

endmodule

/* rtl/bebm_format.sv */
`timescale 1ns / 1ps

module bebm_format (
   input  logic [63:0]         rd_word,
   input  bebm_pkg::meta_type  meta,
   output logic [63:0]         value
);
   import bebm_pkg::*;

   logic [3:0] nbytes;
   logic       sign;
   logic [7:0] fill;
   logic [2:0] src [LANES];

   assign nbytes = 4'd1 << meta.size;
   assign sign   = rd_word[{meta.offset, 3'b111}];
   assign fill   = (meta.sext && (meta.size != SIZE_DWORD[1:0]) && sign) ? BYTE_ONES : 8'h00;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         src[j] = 3'({1'b0, meta.offset} + nbytes - 4'd1 - 4'(j));
         if (!meta.read_ok) begin
            value[8*j +: 8] = 8'h00;
         end else if (4'(j) < nbytes) begin
            value[8*j +: 8] = rd_word[{src[j], 3'b000} +: 8];
         end else begin
            value[8*j +: 8] = fill;
         end
      end
   end

endmodule

/* rtl/big_endian_byte_memory.sv */
`timescale 1ns / 1ps
// A result beat is registered first in the synchronous read register of the 64-bit row
// memory and then in the output register. Throughput: one access per cycle while the
// result side does not stall; all eight byte lanes work in parallel.
// Reset: a clearing pass writes zero to one row per cycle through every row of the
// memory; no request is taken until it ends.
module big_endian_byte_memory #(
   parameter int MEM_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   bebm_req_if.sink   req_chan,
   bebm_rsp_if.source rsp_chan
);
   import bebm_pkg::*;

   localparam int WORDS = (MEM_BYTES + 7) / 8;
   localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(WORDS - 1);

   logic             clearing_ff, clearing_in;
   logic [ROW_W-1:0] clear_row_ff, clear_row_in;
   logic             s1_valid_ff, s1_valid_in;
   meta_type         s1_meta_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff;
   trap_type         rsp_trap_ff;

   logic             accept;
   logic             out_free;
   logic [ROW_W-1:0] acc_row;
   access_type       acc;
   logic             ram_wr_en;
   logic [ROW_W-1:0] ram_wr_row;
   logic [7:0]       ram_wr_be;
   logic [63:0]      ram_wr_data;
   logic [63:0]      ram_rd_data;
   logic [63:0]      fmt_value;

   bebm_decode #(
      .MEM_BYTES(MEM_BYTES),
      .ROW_W(ROW_W)
   ) u_decode (
      .operation  (req_chan.operation),
      .address    (req_chan.address),
      .access_size(req_chan.access_size),
      .sign_extend(req_chan.sign_extend),
      .write_data (req_chan.write_data),
      .row        (acc_row),
      .acc        (acc)
   );

   bebm_ram #(
      .DEPTH(WORDS),
      .ROW_W(ROW_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_row (ram_wr_row),
      .wr_be  (ram_wr_be),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_row (acc_row),
      .rd_data(ram_rd_data)
   );

   bebm_format u_format (
      .rd_word(ram_rd_data),
      .meta   (s1_meta_ff),
      .value  (fmt_value)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !clearing_ff && (!s1_valid_ff || out_free);
   assign accept         = req_chan.valid && req_chan.ready;

   // The clearing pass owns the write port until it ends.
   assign ram_wr_en   = clearing_ff || (accept && acc.write_en);
   assign ram_wr_row  = clearing_ff ? clear_row_ff : acc_row;
   assign ram_wr_be   = clearing_ff ? 8'hFF : acc.byte_en;
   assign ram_wr_data = clearing_ff ? 64'd0 : acc.lane_data;

   always_comb begin
      clearing_in  = clearing_ff && (clear_row_ff != LAST_ROW);
      clear_row_in = clearing_ff ? clear_row_ff + 1'b1 : clear_row_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_row_ff <= clear_row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff.read_ok <= acc.read_ok;
         s1_meta_ff.trap    <= acc.trap;
         s1_meta_ff.offset  <= acc.offset;
         s1_meta_ff.size    <= acc.size;
         s1_meta_ff.sext    <= acc.sext;
      end
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= fmt_value;
         rsp_trap_ff <= s1_meta_ff.trap;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.trap_code = rsp_trap_ff;

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> clearing_ff)
      else $error("clearing pass did not start after reset");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !accept)
      else $error("request taken during clearing pass");

   a_stalled_read_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(ram_rd_data)))
      else $error("pending read lost while result stalled");

   a_trap_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.trap_code != TRAP_NONE) |-> (rsp_chan.read_data == 64'd0))
      else $error("trapped access returned data");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import bebm_pkg::*;

   localparam int unsigned MEM_SIZE     = 65536;
   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam logic [2:0]  BAD_SIZE_LO  = 3'd4;
   localparam logic [2:0]  BAD_SIZE_HI  = 3'd7;

   typedef struct {
      op_type      op;
      logic [31:0] address;
      logic [2:0]  size;
      logic        sx;
      logic [63:0] data;
   } mem_access_type;

   typedef struct {
      logic [63:0] read_data;
      trap_type    trap;
   } access_reply_type;

   // Byte image of the memory plus the replies that accepted accesses still owe.
   class mem_shadow_type;
      logic [7:0]       image [MEM_SIZE];
      access_reply_type owed [$];
      int unsigned      errors;
      int unsigned      replies;

      function new();
         foreach (image[i]) image[i] = 8'h00;
         errors  = 0;
         replies = 0;
      endfunction

      function void take_access(mem_access_type a);
         access_reply_type r;
         int unsigned      nbytes;
         int unsigned      i;
         longint unsigned  span_end;
         r.read_data = '0;
         r.trap      = TRAP_NONE;
         if (a.size > SIZE_DWORD) begin
            r.trap = (a.address >= MEM_SIZE) ? TRAP_RANGE : TRAP_ALIGN;
         end else begin
            nbytes   = 1 << a.size;
            // Widened so that an access near the top of the address space cannot wrap.
            span_end = 64'(a.address) + nbytes;
            if (span_end > MEM_SIZE) begin
               r.trap = TRAP_RANGE;
            end else if ((a.address & (nbytes - 1)) != 0) begin
               r.trap = TRAP_ALIGN;
            end else if (a.op == OP_WRITE) begin
               for (i = 0; i < nbytes; i++)
                  image[a.address + i] = a.data[8 * (nbytes - 1 - i) +: 8];
            end else begin
               for (i = 0; i < nbytes; i++)
                  r.read_data = {r.read_data[55:0], image[a.address + i]};
               if (a.sx && nbytes < LANES && r.read_data[8 * nbytes - 1])
                  r.read_data |= ~((64'd1 << (8 * nbytes)) - 64'd1);
            end
         end
         owed.push_back(r);
      endfunction

      function void check_reply(logic [63:0] data, logic [1:0] trap);
         access_reply_type want;
         replies++;
         if (owed.size() == 0) begin
            $display("%0t: unexpected reply, read_data %h trap %0d", $time, data, trap);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data, data);
            errors++;
         end
         if (trap !== want.trap) begin
            $display("%0t: trap_code expected %0d actual %0d", $time, want.trap, trap);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   mem_shadow_type shadow;

   bebm_req_if req_chan ();
   bebm_rsp_if rsp_chan ();

   big_endian_byte_memory #(.MEM_BYTES(MEM_SIZE)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mem_access_type mk(op_type op, logic [31:0] address, logic [2:0] size,
                                         logic sx, logic [63:0] data);
      mem_access_type a;
      a.op      = op;
      a.address = address;
      a.size    = size;
      a.sx      = sx;
      a.data    = data;
      return a;
   endfunction

   // Mostly aligned accesses inside three small windows so that reads find earlier
   // writes; the rest is misaligned, aligned anywhere, bad size codes and wild addresses.
   function automatic mem_access_type random_access();
      mem_access_type a;
      int unsigned    pick;
      int unsigned    nbytes;
      logic [31:0]    base;
      pick    = $urandom_range(0, 99);
      a.op    = op_type'($urandom_range(0, 1));
      a.sx    = 1'($urandom_range(0, 1));
      a.data  = {$urandom, $urandom};
      a.size  = 3'($urandom_range(SIZE_BYTE, SIZE_DWORD));
      nbytes  = 1 << a.size;
      base    = $urandom_range(0, 2) * (MEM_SIZE / 2 - 32);
      if (pick < 70) begin
         a.address = base + ($urandom_range(0, 63) & ~(nbytes - 1));
      end else if (pick < 80) begin
         a.address = base + $urandom_range(0, 63);
      end else if (pick < 88) begin
         a.address = $urandom_range(0, MEM_SIZE - 1) & ~(nbytes - 1);
      end else if (pick < 93) begin
         a.size    = 3'($urandom_range(BAD_SIZE_LO, BAD_SIZE_HI));
         a.address = $urandom_range(0, 1) ? base + $urandom_range(0, 63) : $urandom;
      end else begin
         a.size    = 3'($urandom_range(0, 7));
         a.address = $urandom;
      end
      return a;
   endfunction

   task automatic send(mem_access_type a);
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= a.op;
      req_chan.address     <= a.address;
      req_chan.access_size <= a.size;
      req_chan.sign_extend <= a.sx;
      req_chan.write_data  <= a.data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      shadow.take_access(a);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      shadow = new();
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_READ;
      req_chan.address     <= '0;
      req_chan.access_size <= SIZE_BYTE;
      req_chan.sign_extend <= 1'b0;
      req_chan.write_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Big-endian lane order, extension of each width, traps and the edges of memory.
      send(mk(OP_READ,  0, SIZE_DWORD, 1'b1, 64'h0));
      send(mk(OP_WRITE, 0, SIZE_DWORD, 1'b0, 64'h0123_4567_89AB_CDEF));
      send(mk(OP_READ,  0, SIZE_BYTE,  1'b0, 64'h0));
      send(mk(OP_READ,  7, SIZE_BYTE,  1'b1, 64'h0));
      send(mk(OP_READ,  6, SIZE_HALF,  1'b1, 64'h0));
      send(mk(OP_READ,  6, SIZE_HALF,  1'b0, 64'h0));
      send(mk(OP_READ,  4, SIZE_WORD,  1'b1, 64'h0));
      send(mk(OP_READ,  0, SIZE_DWORD, 1'b1, 64'h0));
      send(mk(OP_WRITE, 3, SIZE_BYTE,  1'b0, 64'hFFFF_FFFF_FFFF_FF80));
      send(mk(OP_WRITE, 10, SIZE_HALF, 1'b0, 64'hAAAA_AAAA_AAAA_8001));
      send(mk(OP_WRITE, 12, SIZE_WORD, 1'b0, 64'h5555_5555_FEDC_BA98));
      send(mk(OP_READ,  8, SIZE_DWORD, 1'b0, 64'h0));
      send(mk(OP_WRITE, 1, SIZE_HALF,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send(mk(OP_READ,  2, SIZE_WORD,  1'b1, 64'h0));
      send(mk(OP_WRITE, 4, SIZE_DWORD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send(mk(OP_READ,  0, SIZE_DWORD, 1'b0, 64'h0));
      send(mk(OP_READ,  0, 3'd5, 1'b1, 64'h0));
      send(mk(OP_WRITE, 5, BAD_SIZE_HI, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send(mk(OP_READ,  MEM_SIZE, BAD_SIZE_LO, 1'b0, 64'h0));
      send(mk(OP_WRITE, MEM_SIZE - 8, SIZE_DWORD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      send(mk(OP_READ,  MEM_SIZE - 8, SIZE_DWORD, 1'b1, 64'h0));
      send(mk(OP_READ,  MEM_SIZE - 4, SIZE_DWORD, 1'b0, 64'h0));
      send(mk(OP_READ,  MEM_SIZE - 1, SIZE_BYTE,  1'b1, 64'h0));
      send(mk(OP_READ,  MEM_SIZE, SIZE_BYTE, 1'b0, 64'h0));
      send(mk(OP_WRITE, 32'hFFFF_FFF8, SIZE_DWORD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 700) begin
            req_chan.valid <= 1'b0;
            while (shadow.owed.size() != 0) @(posedge clock);
         end
         // Outside beats 300 to 549, a one-cycle gap comes before about one beat
         // in five.
         if ((n < 300 || n >= 550) && $urandom_range(0, 99) < 20)
            pause_sender(1);
         send(random_access());
      end
      req_chan.valid <= 1'b0;

      while (shadow.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // Result side: random back-pressure, one long hold-off that lets the block
   // fill up, and a stretch that takes every beat.
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && shadow.replies >= 200) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (shadow.replies >= 850 && shadow.replies < 1100) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         shadow.check_reply(rsp_chan.read_data, rsp_chan.trap_code);
   end

   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/bebm_pkg.sv
rtl/bebm_if.sv
rtl/bebm_ram.sv
rtl/bebm_decode.sv
rtl/bebm_format.sv
rtl/big_endian_byte_memory.sv
bench/tb.sv
